>>> sv/rpcf_pkg.sv
// ----------------------------------------------------------------------------
// rpcf_pkg
// shared constants of the roi peak channel finder: field widths, register
// indexes and parameter defaults
// ----------------------------------------------------------------------------
`default_nettype none

package rpcf_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE_TWO_D    = 3'd0;
  localparam logic [2:0] CFG_DIM_X         = 3'd1;
  localparam logic [2:0] CFG_DIM_Y         = 3'd2;
  localparam logic [2:0] CFG_ZOOMED        = 3'd3;
  localparam logic [2:0] CFG_WINDOW_X_LOW  = 3'd4;
  localparam logic [2:0] CFG_WINDOW_X_HIGH = 3'd5;
  localparam logic [2:0] CFG_WINDOW_Y_LOW  = 3'd6;
  localparam logic [2:0] CFG_WINDOW_Y_HIGH = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int DIM_W       = 13;  // dim_x, dim_y registers
  localparam int WIN_W       = 12;  // window limit registers
  localparam int CFG_DATA_W  = 13;  // widest register
  localparam int COUNT_W     = 32;  // channel_count, peak_count fields
  localparam int COORD_W     = 12;  // peak_x, peak_y fields
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 56;

  localparam int DEFAULT_MAX_DIM    = 4096;
  localparam int DEFAULT_COUNT_BITS = 32;

endpackage

`default_nettype wire

>>> sv/roi_peak_channel_finder.sv
// ----------------------------------------------------------------------------
// roi_peak_channel_finder
// windowed argmax over a 1-d or 2-d histogram streamed in row-major order
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one channel count per request (tdata = channel_count, tlast
//   marks the final channel of the spectrum). the block keeps its own column
//   and row counters and tracks the tallest channel inside the region of
//   interest. m_* carries one result per spectrum (tdata = peak_count,
//   peak_x, peak_y), sent for the request that had tlast set.
//   cfg_we / cfg_index / cfg_data write the eight setup registers; write
//   them between spectra.
// timing:
//   one channel per clock, sustained while s_tready is high. each channel is
//   compared and the best-so-far updated in the cycle it is accepted; with the
//   output free the result appears on m_tvalid in the cycle after the last channel is taken.
// reset:
//   rst clears the counters, the running best and both result valids and
//   loads the setup registers with their defaults (1-d, 4096 x 1, no zoom).
// stall:
//   a held result sits in the output register, a second one in a spare
//   register; s_tready drops only while the spare register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module roi_peak_channel_finder #(
  parameter int MAX_DIM    = rpcf_pkg::DEFAULT_MAX_DIM,
  parameter int COUNT_BITS = rpcf_pkg::DEFAULT_COUNT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // channel stream in
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rpcf_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] channel_count
  input  wire logic                              s_tlast,   // last_channel
  // peak result out
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [rpcf_pkg::OUT_DATA_W-1:0]        m_tdata,   // [31:0] peak_count,
                                                            // [43:32] peak_x,
                                                            // [55:44] peak_y
  // setup registers
  input  wire logic                              cfg_we,
  input  wire logic [rpcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [rpcf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // largest usable dimension: the dim registers top out at 8191
  localparam int DIM_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
  localparam int EW      = $clog2(DIM_CAP + 1);   // holds an effective dimension
  localparam int POS_W   = $clog2(DIM_CAP);       // holds a position
  localparam int LW      = ((EW > rpcf_pkg::WIN_W) ? EW : rpcf_pkg::WIN_W) + 2;

  // setup registers
  logic                          mode_two_d;
  logic [rpcf_pkg::DIM_W-1:0]    dim_x;
  logic [rpcf_pkg::DIM_W-1:0]    dim_y;
  logic                          zoomed;
  logic [rpcf_pkg::WIN_W-1:0]    window_x_low;
  logic [rpcf_pkg::WIN_W-1:0]    window_x_high;
  logic [rpcf_pkg::WIN_W-1:0]    window_y_low;
  logic [rpcf_pkg::WIN_W-1:0]    window_y_high;

  // scan state
  logic [POS_W-1:0]      column_pos, column_pos_next;
  logic [POS_W-1:0]      row_pos, row_pos_next;
  logic [COUNT_BITS-1:0] best_count, best_count_next;
  logic [POS_W-1:0]      best_column, best_column_next;
  logic [POS_W-1:0]      best_row, best_row_next;

  logic [rpcf_pkg::OUT_DATA_W-1:0] result_next;

  // spare result register behind the output register
  logic                            spare_valid;
  logic [rpcf_pkg::OUT_DATA_W-1:0] spare_data;

  logic                   in_accept;
  logic                   out_accept;
  logic                   out_free;
  logic                   result_push;
  logic [COUNT_BITS-1:0]  count;
  logic [EW-1:0]          dx, dy;
  logic [EW-1:0]          col_inc, row_inc;
  logic signed [LW-1:0]   dxs, dys, xl, xh, yl, yh, col_s, row_s;
  logic                   in_x, in_y, win;
  logic [12:0]            best_col_wide, best_row_wide;
  logic [rpcf_pkg::COORD_W-1:0] peak_x, peak_y;

  assign in_accept   = s_tvalid && s_tready;
  assign out_accept  = m_tvalid && m_tready;
  assign out_free    = !m_tvalid || out_accept;
  assign result_push = in_accept && s_tlast;
  assign s_tready    = !spare_valid;
  assign count       = s_tdata[COUNT_BITS-1:0];

  // ---- setup register writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_two_d    <= 1'b0;
      dim_x         <= rpcf_pkg::DIM_W'(4096);
      dim_y         <= rpcf_pkg::DIM_W'(1);
      zoomed        <= 1'b0;
      window_x_low  <= '0;
      window_x_high <= '1;
      window_y_low  <= '0;
      window_y_high <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        rpcf_pkg::CFG_MODE_TWO_D:    mode_two_d    <= cfg_data[0];
        rpcf_pkg::CFG_DIM_X:         dim_x         <= cfg_data;
        rpcf_pkg::CFG_DIM_Y:         dim_y         <= cfg_data;
        rpcf_pkg::CFG_ZOOMED:        zoomed        <= cfg_data[0];
        rpcf_pkg::CFG_WINDOW_X_LOW:  window_x_low  <= cfg_data[rpcf_pkg::WIN_W-1:0];
        rpcf_pkg::CFG_WINDOW_X_HIGH: window_x_high <= cfg_data[rpcf_pkg::WIN_W-1:0];
        rpcf_pkg::CFG_WINDOW_Y_LOW:  window_y_low  <= cfg_data[rpcf_pkg::WIN_W-1:0];
        rpcf_pkg::CFG_WINDOW_Y_HIGH: window_y_high <= cfg_data[rpcf_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- effective dimensions and region limits ----
  always_comb begin
    // dim_x clamped to 3..MAX_DIM, dim_y to 1..MAX_DIM
    if (dim_x < rpcf_pkg::DIM_W'(3)) begin
      dx = EW'(3);
    end else if (32'(dim_x) > 32'(DIM_CAP)) begin
      dx = EW'(DIM_CAP);
    end else begin
      dx = EW'(dim_x);
    end
    if (dim_y == '0) begin
      dy = EW'(1);
    end else if (32'(dim_y) > 32'(DIM_CAP)) begin
      dy = EW'(DIM_CAP);
    end else begin
      dy = EW'(dim_y);
    end

    dxs   = $signed(LW'(dx));
    dys   = $signed(LW'(dy));
    col_s = $signed(LW'(column_pos));
    row_s = $signed(LW'(row_pos));

    // end channels always excluded; zoom narrows from there
    if (zoomed && window_x_low != '0) begin
      xl = $signed(LW'(window_x_low));
    end else begin
      xl = LW'(1);
    end
    if (zoomed && $signed(LW'(window_x_high)) < dxs - LW'(1)) begin
      xh = $signed(LW'(window_x_high));
    end else begin
      xh = dxs - LW'(2);
    end
    if (zoomed && window_y_low != '0) begin
      yl = $signed(LW'(window_y_low));
    end else begin
      yl = LW'(1);
    end
    if (zoomed && $signed(LW'(window_y_high)) < dys - LW'(1)) begin
      yh = $signed(LW'(window_y_high));
    end else begin
      yh = dys - LW'(2);   // goes negative for a single row: empty region
    end

    in_x = (col_s >= xl) && (col_s <= xh);
    in_y = (row_s >= yl) && (row_s <= yh);
  end

  // ---- compare and update ----
  always_comb begin
    // 2-d: last tie wins; 1-d: first tie wins and only row 0 counts
    if (mode_two_d) begin
      win = in_x && in_y && (count >= best_count);
    end else begin
      win = in_x && (row_pos == '0) && (count > best_count);
    end

    best_count_next  = best_count;
    best_column_next = best_column;
    best_row_next    = best_row;
    if (win) begin
      best_count_next  = count;
      best_column_next = column_pos;
      if (mode_two_d) begin
        best_row_next = row_pos;
      end
    end

    // position counters: column wraps at dx, row wraps at dy
    col_inc = EW'(column_pos) + EW'(1);
    row_inc = EW'(row_pos) + EW'(1);
    if (col_inc >= dx) begin
      column_pos_next = '0;
      row_pos_next    = (row_inc >= dy) ? '0 : row_inc[POS_W-1:0];
    end else begin
      column_pos_next = col_inc[POS_W-1:0];
      row_pos_next    = row_pos;
    end

    // result, taken after the last channel has been examined
    best_col_wide = 13'(best_column_next);
    best_row_wide = 13'(best_row_next);
    if (mode_two_d) begin
      peak_x = best_col_wide[rpcf_pkg::COORD_W-1:0];
      peak_y = best_row_wide[rpcf_pkg::COORD_W-1:0];
    end else begin
      // nothing above zero: report the low x limit in force
      peak_x = (best_count_next == '0) ? xl[rpcf_pkg::COORD_W-1:0]
                                       : best_col_wide[rpcf_pkg::COORD_W-1:0];
      peak_y = '0;
    end
    result_next = {peak_y, peak_x, rpcf_pkg::COUNT_W'(best_count_next)};
  end

  // ---- scan state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos  <= '0;
      row_pos     <= '0;
      best_count  <= '0;
      best_column <= '0;
      best_row    <= '0;
    end else if (in_accept) begin
      if (s_tlast) begin
        // spectrum done: restart for the next one
        column_pos  <= '0;
        row_pos     <= '0;
        best_count  <= '0;
        best_column <= '0;
        best_row    <= '0;
      end else begin
        column_pos  <= column_pos_next;
        row_pos     <= row_pos_next;
        best_count  <= best_count_next;
        best_column <= best_column_next;
        best_row    <= best_row_next;
      end
    end
  end

  // ---- output and spare registers ----
  // a new result goes to the output when it is free and the spare is empty, else to the spare
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      spare_valid <= 1'b0;
    end else if (out_free) begin
      if (spare_valid) begin
        m_tvalid    <= 1'b1;
        spare_valid <= result_push;
      end else begin
        m_tvalid    <= result_push;
      end
    end else if (result_push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (spare_valid) begin
        m_tdata <= spare_data;
        if (result_push) begin
          spare_data <= result_next;
        end
      end else if (result_push) begin
        m_tdata <= result_next;
      end
    end else if (result_push) begin
      spare_data <= result_next;
    end
  end

  // ---- assertions ----
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast |=> m_tvalid)
    else $error("no result after last channel");

  a_scan_restarts: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast |=> column_pos == '0 && row_pos == '0 && best_count == '0)
    else $error("scan state not cleared after last channel");

  a_spare_behind_output: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> m_tvalid)
    else $error("spare result held with the output register empty");

  a_one_d_row_zero: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast && !mode_two_d |->
      result_next[rpcf_pkg::OUT_DATA_W-1 -: rpcf_pkg::COORD_W] == '0)
    else $error("1-d result with nonzero peak_y");

  a_no_count_without_item: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> best_count == $past(best_count))
    else $error("best count moved without an accepted channel");

endmodule

`default_nettype wire
